// File: rtl/lrd_pkg.sv
// ----------------------------------------------------------------------------
// lrd_pkg: shared types and constants
// Request/result payload structs, operation codes, controller states and the
// struct that carries one cycle's orders down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lrd_pkg;

    localparam int unsigned DIST_W = 10;
    localparam int unsigned BIN_W  = 10;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned KEY_W  = 32;
    localparam int unsigned SEL_W  = 12;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned MAXI_W = 11;
    localparam int unsigned IPS_W  = 16;

    localparam logic [ADDR_W-1:0] REG_MAX_ITEMS      = 3'd0;
    localparam logic [ADDR_W-1:0] REG_ITEMS_PER_SLAB = 3'd4;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] key_tag;
        logic [SEL_W-1:0] bin_select;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] reuse_distance;
        logic [BIN_W-1:0]  bin_hit;
        logic [CNT_W-1:0]  bin_count;
        logic [CNT_W-1:0]  lookup_hits_total;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_tag;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MATCH,
        ST_DIVIDE,
        ST_HIST_RD,
        ST_HIST_WR,
        ST_DONE
    } state_t;

    // Orders sent to every cell in one cycle.
    typedef struct packed {
        logic shift;   // cells at positions up to shift_lim take the left neighbor
    } chain_ctl_t;

endpackage

`default_nettype wire

// File: rtl/lrd_cell.sv
// ----------------------------------------------------------------------------
// lrd_cell: one recency stack position
// Holds one tag, compares it against the broadcast key and takes the tag of
// its newer neighbor when the stack shifts through it.
// ----------------------------------------------------------------------------
`default_nettype none

module lrd_cell #(
    parameter int unsigned TAG_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                shift_en,
    input  wire logic [TAG_BITS-1:0] tag_in,
    input  wire logic [TAG_BITS-1:0] key,
    output logic      [TAG_BITS-1:0] tag_out,
    output logic                     match
);

    logic [TAG_BITS-1:0] tag_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            tag_reg <= tag_in;
        end
    end

    assign tag_out = tag_reg;
    assign match   = (tag_reg == key);

endmodule

`default_nettype wire

// File: rtl/lrd_divider.sv
// ----------------------------------------------------------------------------
// lrd_divider: restoring divider
// Divides a 16-bit distance by a 16-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lrd_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [15:0]      quotient
);

    logic [15:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] div_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;

    always_comb
    begin
        trial     = {rem_reg[15:0], quo_reg[15]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done     = busy_reg && (cnt_reg == 5'd1);
    assign quotient = quo_next;

endmodule

`default_nettype wire

// File: rtl/lru_reuse_distance_profiler.sv
// ----------------------------------------------------------------------------
// lru_reuse_distance_profiler: shadow LRU stack with reuse-distance histogram
// Path from request accept to result: insert, lookup miss and operation 3 go
// through the chain match and the result state; read adds a histogram read;
// lookup hit goes through chain match, divide, histogram read and write, result.
// One request at a time; the next is accepted the cycle after the result is
// taken. After reset the histogram memory is cleared, one bin a cycle, before
// the first request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_reuse_distance_profiler #(
    parameter int unsigned STACK_DEPTH = 1024,
    parameter int unsigned HIST_BINS   = 4000,
    parameter int unsigned TAG_BITS    = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire lrd_pkg::req_t               in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output lrd_pkg::rsp_t                    out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lrd_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int unsigned OCC_W  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned POS_W  = $clog2(STACK_DEPTH);
    localparam int unsigned HB_W   = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
    localparam int unsigned HBC_W  = $clog2(HIST_BINS + 1);

    // ---------------- configuration ----------------
    logic [lrd_pkg::MAXI_W-1:0] max_items_reg;
    logic [lrd_pkg::IPS_W-1:0]  ips_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_items_reg <= 11'd1024;
            ips_reg       <= 16'd1;
        end
        else if (wr_en)
        begin
            if (paddr == lrd_pkg::REG_MAX_ITEMS)
            begin
                max_items_reg <= pwdata[lrd_pkg::MAXI_W-1:0];
            end
            else if (paddr == lrd_pkg::REG_ITEMS_PER_SLAB)
            begin
                ips_reg <= pwdata[lrd_pkg::IPS_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr == lrd_pkg::REG_MAX_ITEMS)
        begin
            prdata = {21'd0, max_items_reg};
        end
        else if (paddr == lrd_pkg::REG_ITEMS_PER_SLAB)
        begin
            prdata = {16'd0, ips_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // ---------------- state ----------------
    lrd_pkg::state_t  state_reg, state_next;
    lrd_pkg::req_t    req_reg;
    lrd_pkg::rsp_t    rsp_reg, rsp_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [31:0]      lookups_reg, lookups_next;
    logic [HBC_W-1:0] clr_reg, clr_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             found_reg, found_next;
    logic [15:0]      bin_reg, bin_next;
    logic [31:0]      hist_q_reg;

    logic [TAG_BITS-1:0] key;
    assign key = TAG_BITS'(req_reg.key_tag);

    // ---------------- cell chain ----------------
    logic [TAG_BITS-1:0] cell_q [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] cell_match;
    logic [STACK_DEPTH-1:0] cell_shift;
    logic [OCC_W-1:0]       shift_lim;
    lrd_pkg::chain_ctl_t    ctl;

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [TAG_BITS-1:0] left;
        if (i == 0)
        begin : g_head
            assign left = key;
        end
        else
        begin : g_body
            assign left = cell_q[i-1];
        end
        assign cell_shift[i] = ctl.shift && (OCC_W'(i) <= shift_lim);
        lrd_cell #(.TAG_BITS(TAG_BITS)) u_cell (
            .clk      (clk),
            .shift_en (cell_shift[i]),
            .tag_in   (left),
            .key      (key),
            .tag_out  (cell_q[i]),
            .match    (cell_match[i])
        );
    end

    // first valid match, newest first
    logic [STACK_DEPTH-1:0] vmatch;
    logic [POS_W-1:0]       hit_pos;
    logic                   any_hit;
    always_comb
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            vmatch[i] = cell_match[i] && (OCC_W'(i) < occ_reg);
        end
        any_hit = |vmatch;
        hit_pos = '0;
        for (int i = STACK_DEPTH - 1; i >= 0; i--)
        begin
            if (vmatch[i])
            begin
                hit_pos = POS_W'(i);
            end
        end
    end

    // ---------------- divider ----------------
    logic        div_start, div_done;
    logic [15:0] div_q;
    logic [15:0] divisor;
    assign divisor = (ips_reg == '0) ? 16'd1 : ips_reg;

    lrd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (16'(pos_reg)),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------- histogram memory ----------------
    logic [31:0]     hist_mem [HIST_BINS];
    logic            hist_we;
    logic [HB_W-1:0] hist_waddr, hist_raddr;
    logic [31:0]     hist_wdata;

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_q_reg <= hist_mem[hist_raddr];
    end

    // ---------------- control ----------------
    logic [OCC_W-1:0] limit;
    assign limit = (32'(max_items_reg) < STACK_DEPTH) ? OCC_W'(max_items_reg)
                                                      : OCC_W'(STACK_DEPTH);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lrd_pkg::ST_CLEAR:
            begin
                if (32'(clr_reg) == HIST_BINS - 1)
                begin
                    state_next = lrd_pkg::ST_IDLE;
                end
            end
            lrd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lrd_pkg::ST_MATCH;
                end
            end
            lrd_pkg::ST_MATCH:
            begin
                if (req_reg.operation == lrd_pkg::OP_LOOKUP && any_hit)
                begin
                    state_next = lrd_pkg::ST_DIVIDE;
                end
                else if (req_reg.operation == lrd_pkg::OP_READ)
                begin
                    state_next = lrd_pkg::ST_HIST_RD;
                end
                else
                begin
                    state_next = lrd_pkg::ST_DONE;
                end
            end
            lrd_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = lrd_pkg::ST_HIST_RD;
                end
            end
            lrd_pkg::ST_HIST_RD:
            begin
                state_next = found_reg ? lrd_pkg::ST_HIST_WR : lrd_pkg::ST_DONE;
            end
            lrd_pkg::ST_HIST_WR:
            begin
                state_next = lrd_pkg::ST_DONE;
            end
            lrd_pkg::ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = lrd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next     = rsp_reg;
        occ_next     = occ_reg;
        lookups_next = lookups_reg;
        clr_next     = clr_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        bin_next     = bin_reg;
        ctl          = '0;
        shift_lim    = '0;
        hist_we      = 1'b0;
        hist_waddr   = bin_reg[HB_W-1:0];
        hist_wdata   = hist_q_reg + 32'd1;
        hist_raddr   = HB_W'(req_reg.bin_select);
        unique case (state_reg)
            lrd_pkg::ST_CLEAR:
            begin
                hist_we    = 1'b1;
                hist_waddr = clr_reg[HB_W-1:0];
                hist_wdata = '0;
                clr_next   = clr_reg + HBC_W'(1);
            end
            lrd_pkg::ST_IDLE:
            begin
                found_next = 1'b0;
            end
            lrd_pkg::ST_MATCH:
            begin
                rsp_next = '0;
                rsp_next.lookup_hits_total = lookups_reg;
                if (req_reg.operation == lrd_pkg::OP_INSERT)
                begin
                    if (occ_reg + OCC_W'(1) > limit)
                    begin
                        rsp_next.evicted = 1'b1;
                        if (occ_reg == '0)
                        begin
                            rsp_next.evicted_tag = 32'(key);
                        end
                        else
                        begin
                            rsp_next.evicted_tag = 32'(cell_q[POS_W'(occ_reg - OCC_W'(1))]);
                            ctl.shift = 1'b1;
                            shift_lim = occ_reg - OCC_W'(1);
                        end
                    end
                    else
                    begin
                        ctl.shift = 1'b1;
                        shift_lim = occ_reg;
                        occ_next  = occ_reg + OCC_W'(1);
                    end
                end
                else if (req_reg.operation == lrd_pkg::OP_LOOKUP && any_hit)
                begin
                    ctl.shift  = 1'b1;
                    shift_lim  = OCC_W'(hit_pos);
                    pos_next   = hit_pos;
                    found_next = 1'b1;
                    rsp_next.hit = 1'b1;
                    rsp_next.reuse_distance = lrd_pkg::DIST_W'(hit_pos);
                    lookups_next = lookups_reg + 32'd1;
                    rsp_next.lookup_hits_total = lookups_reg + 32'd1;
                end
            end
            lrd_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    bin_next = div_q;
                    rsp_next.bin_hit = div_q[lrd_pkg::BIN_W-1:0];
                end
            end
            lrd_pkg::ST_HIST_RD:
            begin
                if (found_reg)
                begin
                    hist_raddr = bin_reg[HB_W-1:0];
                end
            end
            lrd_pkg::ST_HIST_WR:
            begin
                hist_we = 32'(bin_reg) < HIST_BINS;
            end
            lrd_pkg::ST_DONE:
            begin
                if (!found_reg && 32'(req_reg.bin_select) < HIST_BINS
                    && req_reg.operation == lrd_pkg::OP_READ)
                begin
                    rsp_next.bin_count = hist_q_reg;
                end
            end
            default:
            begin
                rsp_next = rsp_reg;
            end
        endcase
    end

    // divider starts on the cycle after the match
    logic start_reg;
    assign div_start = start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lrd_pkg::ST_CLEAR;
            occ_reg     <= '0;
            lookups_reg <= '0;
            clr_reg     <= '0;
            found_reg   <= 1'b0;
            start_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            lookups_reg <= lookups_next;
            clr_reg     <= clr_next;
            found_reg   <= found_next;
            start_reg   <= (state_reg == lrd_pkg::ST_MATCH) && (state_next == lrd_pkg::ST_DIVIDE);
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        pos_reg <= pos_next;
        bin_reg <= bin_next;
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
    end

    assign in_ready  = (state_reg == lrd_pkg::ST_IDLE);
    assign out_valid = (state_reg == lrd_pkg::ST_DONE);
    assign out_data  = rsp_next;

endmodule

`default_nettype wire
